FILE: src/polyline_ribbon_extruder_top_defines.svh
// Assertion macros for the polyline ribbon extruder
`ifndef POLYLINE_RIBBON_EXTRUDER_TOP_DEFINES_SVH
`define POLYLINE_RIBBON_EXTRUDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PRE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assertion failed");
`define PRE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define PRE_ASSERT_IMP(lbl, a, b)
`define PRE_ASSERT_NXT(lbl, a, b)
`endif
`endif

FILE: src/pre_pkg.sv
// Package: types and constants of the polyline ribbon extruder
`timescale 1ns / 1ps
`default_nettype none
package pre_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF = 32;
  localparam int W_BITS         = 20;
  localparam int Z_BITS         = 24;
  localparam int MAG_BITS       = 30;
  localparam int ROOT_BITS      = 31;
  localparam int DEN_BITS       = 32;
  localparam int QUO_BITS       = 21;
  localparam int NUM_BITS       = 81;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROAD       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARKING    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PEDESTRIAN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT     = 3'd3;

  localparam logic [1:0] CAT_ROAD    = 2'd0;
  localparam logic [1:0] CAT_PARKING = 2'd1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_NORM = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_PROD = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } pre_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pre_div_st_t;
endpackage
`default_nettype wire

FILE: src/pre_in_if.sv
// Interface: input point channel
`timescale 1ns / 1ps
`default_nettype none
interface pre_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [1:0]                   category;
  logic                         first_point;
  modport source (output valid, point_x, point_y, category, first_point, input ready);
  modport sink (input valid, point_x, point_y, category, first_point, output ready);
endinterface
`default_nettype wire

FILE: src/pre_out_if.sv
// Interface: output vertex channel
`timescale 1ns / 1ps
`default_nettype none
interface pre_out_if #(parameter int COORD_BITS = 24, parameter int INDEX_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [INDEX_BITS-1:0]        vertex_index;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [23:0]           vertex_z;
  logic                         last_of_quad;
  modport source (output valid, vertex_index, vertex_x, vertex_y, vertex_z, last_of_quad,
                  input ready);
  modport sink (input valid, vertex_index, vertex_x, vertex_y, vertex_z, last_of_quad,
                output ready);
endinterface
`default_nettype wire

FILE: src/polyline_ribbon_extruder_top.sv
// Top level: polyline to quad-strip extruder with shared multiplier, root and divider
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | point_x, point_y, category, first_point
//  out_ch  | out | valid/ready       | vertex_index, vertex_x, vertex_y, vertex_z, last_of_quad
//  cfg_*   | in  | cfg_we, no wait   | cfg_index, cfg_wdata
//
// A point that closes no segment leaves the block idle. A segment steps through accept,
// squares, normalize, square root (one bit pair per cycle), products, two divisions on the
// shared divider and four vertices, which wait on output stalls.
// The output register lets the last vertex wait while the next point is taken.
// Synchronous reset: state to idle; vertex index, previous point, config regs to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_ribbon_extruder_top_defines.svh"
module polyline_ribbon_extruder_top import pre_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  pre_in_if.sink                        in_ch,
  pre_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);
  localparam int DW = COORD_BITS + 1;
  localparam int EW = 33;
  localparam int SW = ((COORD_BITS > W_BITS + 2) ? COORD_BITS : W_BITS + 2) + 1;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  pre_state_t state_r;
  logic [4:0] cnt_r;
  logic [W_BITS-1:0] road_r, park_r, ped_r;
  logic signed [Z_BITS-1:0] height_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic have_prev_r;
  logic [INDEX_BITS-1:0] next_vtx_r;
  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic dx_neg_r, dy_pos_r;
  logic [W_BITS-1:0] w_r;
  logic [MAG_BITS-1:0] mx_r, my_r;
  logic [2*MAG_BITS-1:0] prod_r, acc_r;
  logic [61:0] v_r;
  logic [4:0] f_r;
  logic [ROOT_BITS+1:0] rem_r;
  logic [ROOT_BITS-1:0] root_r;
  logic [NUM_BITS-1:0] num_a_r, num_b_r;
  logic [QUO_BITS-1:0] offx_r, offy_r;
  logic div_phase_r;
  logic out_valid_r, out_last_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic signed [Z_BITS-1:0] out_z_r;

  logic in_ready, in_acc, seg, zero_len, norm_done, load;
  logic signed [DW-1:0] dx_c, dy_c;
  logic [DW-1:0] adx, ady;
  logic [EW-1:0] mxe, mye;
  logic [1:0] psh;
  logic [W_BITS-1:0] w_c;
  logic [MAG_BITS-1:0] mul_a, mul_b;
  logic [ROOT_BITS+3:0] rt_t, rt_trial;
  logic rt_ge;
  logic [NUM_BITS-1:0] num_c;
  logic div_start;
  logic [NUM_BITS-1:0] div_num;
  pre_div_st_t div_st;
  logic [QUO_BITS-1:0] div_quo;
  logic signed [SW-1:0] mag_x, mag_y, sum_x, sum_y;
  logic signed [COORD_BITS-1:0] base_x, base_y, sat_x, sat_y;

  assign in_ready    = state_r == S_IDLE;
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign seg         = have_prev_r && !in_ch.first_point;
  assign dx_c = {in_ch.point_x[COORD_BITS-1], in_ch.point_x} - {prev_x_r[COORD_BITS-1], prev_x_r};
  assign dy_c = {in_ch.point_y[COORD_BITS-1], in_ch.point_y} - {prev_y_r[COORD_BITS-1], prev_y_r};
  assign zero_len = (dx_c == '0) && (dy_c == '0);
  assign adx = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
  assign ady = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
  assign mxe = EW'(adx);
  assign mye = EW'(ady);

  always_comb begin
    priority if (mxe[32:30] == '0 && mye[32:30] == '0) psh = 2'd0;
    else if (mxe[32:31] == '0 && mye[32:31] == '0)      psh = 2'd1;
    else if (!mxe[32] && !mye[32])                      psh = 2'd2;
    else                                                psh = 2'd3;
  end

  always_comb begin
    unique case (in_ch.category)
      CAT_ROAD:    w_c = road_r;
      CAT_PARKING: w_c = park_r;
      default:     w_c = ped_r;
    endcase
  end

  always_comb begin
    mul_a = mx_r;
    mul_b = mx_r;
    if (state_r == S_SQ && cnt_r == 5'd1) begin
      mul_a = my_r;
      mul_b = my_r;
    end else if (state_r == S_PROD) begin
      mul_a = (cnt_r == 5'd0) ? my_r : mx_r;
      mul_b = MAG_BITS'(w_r);
    end
  end

  assign norm_done = v_r[61] | v_r[60];
  assign rt_t      = {rem_r, v_r[61:60]};
  assign rt_trial  = {2'b00, root_r, 2'b01};
  assign rt_ge     = rt_t >= rt_trial;
  assign num_c     = (NUM_BITS'(prod_r[MAG_BITS+W_BITS-1:0]) << f_r) + NUM_BITS'(root_r);

  assign div_start = (state_r == S_PROD && cnt_r == 5'd2) ||
                     (state_r == S_DIV && div_st.done && !div_phase_r);
  assign div_num   = (state_r == S_PROD) ? num_a_r : num_b_r;

  pre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({root_r, 1'b0}),
    .st    (div_st),
    .quo   (div_quo)
  );

  assign load   = state_r == S_EMIT && (!out_valid_r || out_ch.ready);
  assign base_x = cnt_r[1] ? bx_r : ax_r;
  assign base_y = cnt_r[1] ? by_r : ay_r;
  assign mag_x  = $signed(SW'(offx_r));
  assign mag_y  = $signed(SW'(offy_r));
  assign sum_x  = SW'(base_x) + ((dy_pos_r ^ cnt_r[0]) ? -mag_x : mag_x);
  assign sum_y  = SW'(base_y) + ((dx_neg_r ^ cnt_r[0]) ? -mag_y : mag_y);
  assign sat_x  = (sum_x > HI) ? HI[COORD_BITS-1:0] :
                  (sum_x < LO) ? LO[COORD_BITS-1:0] : sum_x[COORD_BITS-1:0];
  assign sat_y  = (sum_y > HI) ? HI[COORD_BITS-1:0] :
                  (sum_y < LO) ? LO[COORD_BITS-1:0] : sum_y[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      road_r      <= '0;
      park_r      <= '0;
      ped_r       <= '0;
      height_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      next_vtx_r  <= '0;
      div_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROAD:       road_r   <= cfg_wdata[W_BITS-1:0];
          CFG_PARKING:    park_r   <= cfg_wdata[W_BITS-1:0];
          CFG_PEDESTRIAN: ped_r    <= cfg_wdata[W_BITS-1:0];
          CFG_HEIGHT:     height_r <= $signed(cfg_wdata[Z_BITS-1:0]);
          default: ;
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_x_r    <= in_ch.point_x;
            prev_y_r    <= in_ch.point_y;
            have_prev_r <= 1'b1;
            if (seg && !zero_len) begin
              state_r <= S_SQ;
              cnt_r   <= '0;
            end
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd2) state_r <= S_NORM;
        end
        S_NORM: begin
          if (norm_done) begin
            state_r <= S_ROOT;
            cnt_r   <= 5'd30;
          end
        end
        S_ROOT: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_PROD;
            cnt_r   <= '0;
          end
        end
        S_PROD: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd2) begin
            state_r     <= S_DIV;
            div_phase_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (div_phase_r) begin
              state_r <= S_EMIT;
              cnt_r   <= '0;
            end else begin
              div_phase_r <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 5'd3) begin
              state_r    <= S_IDLE;
              next_vtx_r <= next_vtx_r + INDEX_BITS'(4);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      ax_r     <= prev_x_r;
      ay_r     <= prev_y_r;
      bx_r     <= in_ch.point_x;
      by_r     <= in_ch.point_y;
      w_r      <= w_c;
      mx_r     <= MAG_BITS'(mxe >> psh);
      my_r     <= MAG_BITS'(mye >> psh);
      dx_neg_r <= dx_c[DW-1];
      dy_pos_r <= !dy_c[DW-1] && (dy_c != '0);
    end
    if (state_r == S_SQ && cnt_r == 5'd1) acc_r <= prod_r;
    if (state_r == S_SQ && cnt_r == 5'd2) begin
      v_r <= 62'(acc_r) + 62'(prod_r);
      f_r <= '0;
    end
    if (state_r == S_NORM) begin
      if (!norm_done) begin
        v_r <= {v_r[59:0], 2'b00};
        f_r <= f_r + 1'b1;
      end else begin
        rem_r  <= '0;
        root_r <= '0;
      end
    end
    if (state_r == S_ROOT) begin
      v_r    <= {v_r[59:0], 2'b00};
      rem_r  <= rt_ge ? (ROOT_BITS+2)'(rt_t - rt_trial) : rt_t[ROOT_BITS+1:0];
      root_r <= {root_r[ROOT_BITS-2:0], rt_ge};
    end
    if (state_r == S_PROD && cnt_r == 5'd1) num_a_r <= num_c;
    if (state_r == S_PROD && cnt_r == 5'd2) num_b_r <= num_c;
    if (state_r == S_DIV && div_st.done) begin
      if (div_phase_r) offy_r <= div_quo;
      else             offx_r <= div_quo;
    end
    if (load) begin
      out_idx_r  <= next_vtx_r + INDEX_BITS'(cnt_r[1:0]);
      out_x_r    <= sat_x;
      out_y_r    <= sat_y;
      out_z_r    <= height_r;
      out_last_r <= cnt_r[1:0] == 2'd3;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_idx_r;
  assign out_ch.vertex_x     = out_x_r;
  assign out_ch.vertex_y     = out_y_r;
  assign out_ch.vertex_z     = out_z_r;
  assign out_ch.last_of_quad = out_last_r;

  `PRE_ASSERT_IMP(a_div_idle, state_r != S_DIV, !div_st.busy)
  `PRE_ASSERT_IMP(a_emit_cnt, state_r == S_EMIT, cnt_r <= 5'd3)
  `PRE_ASSERT_NXT(a_start_idle, in_acc && in_ch.first_point, in_ch.ready)
endmodule
`default_nettype wire

FILE: src/pre_div.sv
// Module: bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pre_div import pre_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output pre_div_st_t              st,
  output logic [QUO_BITS-1:0]      quo
);
  localparam int CW = $clog2(QUO_BITS + 1);

  logic [DEN_BITS-1:0] rem_r;
  logic [QUO_BITS-1:0] sh_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DEN_BITS:0]   trial;
  logic                ge;

  assign trial = {rem_r, sh_r[QUO_BITS-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(QUO_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QUO_BITS+DEN_BITS-1:QUO_BITS];
      sh_r  <= num[QUO_BITS-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_BITS'(trial - {1'b0, den_r}) : trial[DEN_BITS-1:0];
      sh_r  <= {sh_r[QUO_BITS-2:0], ge};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quo     = sh_r;
endmodule
`default_nettype wire

FILE: bench/tb_chk.sv
// Checker: predicts ribbon quad vertices from accepted points and compares results
`timescale 1ns / 1ps
module tb_chk import pre_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  pre_in_if                        in_ch,
  pre_out_if                       out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending_vertices
);
  typedef struct packed {
    logic [31:0]        idx;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               last;
  } vertex_t;

  vertex_t          vertex_q[$];
  logic [19:0]      w_road, w_park, w_ped;
  logic signed [23:0] z_height;
  logic signed [23:0] px, py;
  logic             has_prev;
  logic [31:0]      vtx_next;

  assign pending_vertices = vertex_q.size();

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic extrude(logic signed [23:0] bx, logic signed [23:0] by, logic [1:0] cat,
                         logic first);
    longint dx, dy, ox, oy, ax, ay;
    longint unsigned mx, my, l2, s, w, nb;
    int f, bl;
    longint vx[4], vy[4];
    vertex_t v;
    ax = px;
    ay = py;
    px = bx;
    py = by;
    if (!has_prev || first) begin
      has_prev = 1;
      return;
    end
    dx = longint'(bx) - ax;
    dy = longint'(by) - ay;
    if (dx == 0 && dy == 0) return;
    w = (cat == CAT_ROAD) ? w_road : (cat == CAT_PARKING) ? w_park : w_ped;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
      mx >>= 1;
      my >>= 1;
    end
    l2 = mx * mx + my * my;
    bl = 0;
    nb = l2;
    while (nb != 0) begin
      bl++;
      nb >>= 1;
    end
    f = (62 - bl) / 2;
    s = root64(l2 << (2 * f));
    ox = (((my * w) << f) + s) / (2 * s);
    if (dy > 0) ox = -ox;
    oy = (((mx * w) << f) + s) / (2 * s);
    if (dx < 0) oy = -oy;
    vx[0] = ax + ox; vy[0] = ay + oy;
    vx[1] = ax - ox; vy[1] = ay - oy;
    vx[2] = bx + ox; vy[2] = by + oy;
    vx[3] = bx - ox; vy[3] = by - oy;
    for (int k = 0; k < 4; k++) begin
      v.idx = vtx_next + 32'(k);
      v.x = clamp24(vx[k]);
      v.y = clamp24(vy[k]);
      v.z = z_height;
      v.last = (k == 3);
      vertex_q.push_back(v);
    end
    vtx_next += 4;
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      w_road <= 0; w_park <= 0; w_ped <= 0; z_height <= 0;
      px = 0; py = 0; has_prev = 0; vtx_next = 0;
      fail_count = 0;
      vertex_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROAD:       w_road <= cfg_wdata[19:0];
          CFG_PARKING:    w_park <= cfg_wdata[19:0];
          CFG_PEDESTRIAN: w_ped <= cfg_wdata[19:0];
          CFG_HEIGHT:     z_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        extrude(in_ch.point_x, in_ch.point_y, in_ch.category, in_ch.first_point);
      if (out_ch.valid && out_ch.ready) begin
        if (vertex_q.size() == 0) begin
          report("unexpected vertex", out_ch.vertex_index, 0);
        end else begin
          e = vertex_q.pop_front();
          if (out_ch.vertex_index !== e.idx) report("vertex_index", out_ch.vertex_index, e.idx);
          if (out_ch.vertex_x !== e.x) report("vertex_x", out_ch.vertex_x, e.x);
          if (out_ch.vertex_y !== e.y) report("vertex_y", out_ch.vertex_y, e.y);
          if (out_ch.vertex_z !== e.z) report("vertex_z", out_ch.vertex_z, e.z);
          if (out_ch.last_of_quad !== e.last) report("last_of_quad", out_ch.last_of_quad, e.last);
        end
      end
    end
  end
endmodule

FILE: bench/tb_top.sv
// Testbench top: stimulus, idling and output-stall phases, configuration and verdict for the extruder
`timescale 1ns / 1ps
module tb_top;
  import pre_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd5;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = 0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = 0;
  int fail_count, pending_vertices;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;
  logic signed [23:0] cur_x = 0, cur_y = 0;

  pre_in_if  #(.COORD_BITS(24)) in_ch();
  pre_out_if #(.COORD_BITS(24), .INDEX_BITS(32)) out_ch();

  polyline_ribbon_extruder_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tb_chk chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending_vertices(pending_vertices)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.point_x = 0;
    in_ch.point_y = 0;
    in_ch.category = 0;
    in_ch.first_point = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(logic signed [23:0] x, logic signed [23:0] y, logic [1:0] cat,
                      logic first);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.category <= cat;
    in_ch.first_point <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_vertices != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_widths(logic [19:0] r, logic [19:0] p, logic [19:0] d, logic [23:0] z);
    write_reg(CFG_ROAD, 24'(r));
    write_reg(CFG_PARKING, 24'(p));
    write_reg(CFG_PEDESTRIAN, 24'(d));
    write_reg(CFG_HEIGHT, z);
    write_reg(CFG_UNUSED, 24'hffffff);
    cfg_we <= 0;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return cur_x + $signed(24'($urandom_range(4000)) - 24'sd2000);
    endcase
  endfunction

  task automatic run_random(int n);
    logic signed [23:0] x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        x = 24'($urandom);
        y = 24'($urandom);
      end else begin
        x = rand_coord();
        y = ($urandom_range(3) == 0) ? cur_y : cur_y + $signed(24'($urandom_range(4000)) - 24'sd2000);
        if ($urandom_range(15) == 0) y = 24'($urandom);
        if ($urandom_range(19) == 0) x = cur_x;
      end
      if ($urandom_range(19) == 0) begin
        x = cur_x;
        y = cur_y;
      end
      cur_x = x;
      cur_y = y;
      send(x, y, 2'($urandom_range(3)), $urandom_range(9) == 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(24'sd100, 24'sd100, CAT_ROAD, 0);
    send(24'sd200, 24'sd100, CAT_ROAD, 0);
    drain();
    set_widths(20'd160, 20'd48, 20'd32, 24'sd250);
    send(24'sd0, 24'sd0, CAT_ROAD, 1);
    send(24'sd1600, 24'sd0, CAT_ROAD, 0);
    send(24'sd1600, 24'sd0, CAT_PARKING, 0);
    send(24'sd1600, 24'sd1600, CAT_PARKING, 0);
    send(-24'sd1600, -24'sd1600, 2'd2, 0);
    send(-24'sd1600, 24'sd5, 2'd3, 0);
    send(24'sh7fffff, 24'sh7fffff, CAT_ROAD, 1);
    send(24'sh800000, 24'sh800000, CAT_ROAD, 0);
    send(24'sh7fffff, 24'sh800000, CAT_PARKING, 0);
    send(24'sh7ffff0, 24'sh800001, 2'd2, 0);
    send(24'sd1, 24'sd0, CAT_ROAD, 1);
    send(24'sd0, 24'sd1, CAT_ROAD, 0);
    send(24'sd5, 24'sh7fff00, 2'd3, 0);
    drain();
    set_widths(20'hfffff, 20'hfffff, 20'hfffff, 24'sh800000);
    send(24'sd0, 24'sd0, CAT_ROAD, 1);
    send(24'sd3, 24'sd1, CAT_ROAD, 0);
    send(24'sh7fffff, 24'sd1, CAT_PARKING, 0);
    send(24'sh800000, -24'sd7, 2'd3, 0);
    send(24'sh800000, 24'sh7fffff, 2'd2, 0);
    drain();
    set_widths(20'($urandom), 20'($urandom), 20'($urandom), 24'sh7fffff);
    run_random(120);
    drain();
    set_widths(20'($urandom_range(4000)), 20'($urandom_range(4000)),
               20'($urandom_range(4000)), 24'($urandom));
    idle_pct = 58;
    run_random(110);
    drain();
    set_widths(20'($urandom), 20'($urandom_range(800)), 20'd0, 24'($urandom));
    idle_pct = 0;
    stall_pct = 58;
    run_random(110);
    drain();
    set_widths(20'($urandom_range(2000)), 20'($urandom), 20'($urandom_range(2000)),
               24'($urandom));
    idle_pct = 20;
    stall_pct = 20;
    run_random(110);
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/pre_pkg.sv
src/pre_in_if.sv
src/pre_out_if.sv
src/pre_div.sv
src/polyline_ribbon_extruder_top.sv
bench/tb_chk.sv
bench/tb_top.sv
